### src/nfc_pkg.sv
package nfc_pkg;

  localparam int unsigned CHANNELS  = 8;
  localparam int unsigned MAX_FOLD  = 8;

  localparam int unsigned TIME_W    = 64;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned CNT_W     = 48;
  localparam int unsigned WLEN_W    = 32;
  localparam int unsigned FOLD_W    = 4;
  localparam int unsigned MEMBERS_W = 24;

  localparam int unsigned CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int unsigned IN_TDATA_W  = ((TIME_W + CH_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((CNT_W + MEMBERS_W + 7) / 8) * 8;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD          = 1'b1;

  localparam logic [FOLD_W-1:0] FOLD_RESET = 4'd2;
  localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [TIME_W-1:0] time_t;

endpackage

### src/nfold_coincidence_detector.sv
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/s_axis_tready tdata: event_time, event_channel
// m_axis    out  m_axis_tvalid/m_axis_tready tdata: singles_count,
//                                            coincidence_members; tuser: found
// cfg       in   cfg_we_i (no wait)          cfg_idx_i, cfg_wdata_i
//
// one request per cycle sustained while m_axis_tready takes each result
// a request is registered, then evaluated and applied to the window state in
// one pass into the result register
// a waiting result holds the input register; one more request is taken while
// that register is empty, then s_axis_tready stays low until the result leaves
// rst_ni asynchronous, active low: window closed, counters cleared, fold 2
module nfold_coincidence_detector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // event_time [63:0], event_channel [66:64], zero fill
  input  logic [nfc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // singles_count [47:0], coincidence_members [71:48]
  output logic [nfc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // coincidence_found [0]
  output logic                               m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_we_i,
  input  logic [nfc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [nfc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import nfc_pkg::*;

  // config
  logic [WLEN_W-1:0] wlen_q;
  logic [FOLD_W-1:0] fold_q;

  // input register
  logic  in_valid_q;
  time_t in_time_q;
  chan_t in_ch_q;

  // window state
  logic              open_q, open_d;
  time_t             start_q, start_d;
  logic [FOLD_W-1:0] mcount_q, mcount_d;
  chan_t             members_q [MAX_FOLD];
  chan_t             members_d [MAX_FOLD];
  logic              clean_q, clean_d;
  count_t            singles_q [CHANNELS];

  // result register
  logic                 out_valid_q;
  count_t               out_cnt_q, out_cnt_d;
  logic                 out_found_q, out_found_d;
  logic [MEMBERS_W-1:0] out_members_q, out_members_d;

  logic                advance;
  logic                ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  count_t              cnt_rd, cnt_new;
  time_t               diff;
  logic                in_win;
  logic                fresh;
  logic [FOLD_W-1:0]   f_eff;
  logic [MEMBERS_W-1:0] packed_members;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= '0;
      fold_q <= FOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_LENGTH: wlen_q <= cfg_wdata_i[WLEN_W-1:0];
        REG_FOLD:          fold_q <= cfg_wdata_i[FOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_time_q <= s_axis_tdata[TIME_W-1:0];
      in_ch_q   <= s_axis_tdata[TIME_W +: CH_W];
    end
  end

  always_comb begin
    if (fold_q == '0) begin
      f_eff = FOLD_W'(1);
    end else if (fold_q > FOLD_W'(MAX_FOLD)) begin
      f_eff = FOLD_W'(MAX_FOLD);
    end else begin
      f_eff = fold_q;
    end
  end

  assign ch_ok   = (32'(in_ch_q) < CHANNELS);
  assign ch_idx  = CH_IDX_W'(in_ch_q);
  assign cnt_rd  = singles_q[ch_idx];
  assign cnt_new = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + CNT_W'(1);
  assign diff    = in_time_q - start_q;
  assign in_win  = (diff <= TIME_W'(wlen_q));

  // duplicate check over held members
  always_comb begin
    fresh = 1'b1;
    for (int k = 0; k < MAX_FOLD; k++) begin
      if ((FOLD_W'(k) < mcount_q) && (members_q[k] == in_ch_q)) begin
        fresh = 1'b0;
      end
    end
  end

  always_comb begin
    packed_members = '0;
    for (int k = 0; k < MAX_FOLD; k++) begin
      if (FOLD_W'(k) < mcount_q) begin
        packed_members[k*CH_W +: CH_W] = members_q[k];
      end
    end
  end

  always_comb begin
    open_d        = open_q;
    start_d       = start_q;
    mcount_d      = mcount_q;
    members_d     = members_q;
    clean_d       = clean_q;
    out_cnt_d     = '0;
    out_found_d   = 1'b0;
    out_members_d = '0;
    if (ch_ok) begin
      out_cnt_d = cnt_new;
      if (open_q && in_win) begin
        if (mcount_q < f_eff) begin
          if (fresh) begin
            for (int k = 0; k < MAX_FOLD; k++) begin
              if (FOLD_W'(k) == mcount_q) begin
                members_d[k] = in_ch_q;
              end
            end
            mcount_d = mcount_q + FOLD_W'(1);
          end
        end else begin
          clean_d = 1'b0;
        end
      end else begin
        if (open_q && clean_q && (mcount_q == f_eff)) begin
          out_found_d   = 1'b1;
          out_members_d = packed_members;
        end
        open_d   = 1'b1;
        start_d  = in_time_q;
        mcount_d = FOLD_W'(1);
        clean_d  = 1'b1;
        for (int k = 0; k < MAX_FOLD; k++) begin
          members_d[k] = '0;
        end
        members_d[0] = in_ch_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      start_q  <= '0;
      mcount_q <= '0;
      clean_q  <= 1'b1;
      for (int k = 0; k < MAX_FOLD; k++) begin
        members_q[k] <= '0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        singles_q[c] <= '0;
      end
    end else if (advance) begin
      open_q    <= open_d;
      start_q   <= start_d;
      mcount_q  <= mcount_d;
      clean_q   <= clean_d;
      members_q <= members_d;
      if (ch_ok) begin
        singles_q[ch_idx] <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_cnt_q     <= out_cnt_d;
      out_found_q   <= out_found_d;
      out_members_q <= out_members_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_members_q, out_cnt_q});

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mcount_q <= FOLD_W'(MAX_FOLD))
    else $error("member count above max fold");

  a_open_has_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (mcount_q != '0))
    else $error("open window without members");

  a_closed_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (mcount_q == '0))
    else $error("closed window holds members");

  a_result_from_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("result without evaluated request");

  a_members_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !out_found_d) |=> (out_members_q == '0))
    else $error("members reported without coincidence");

endmodule
